>>> design/aht_pkg.sv
package aht_pkg;

    localparam int RING_DEPTH = 3;
    localparam int SLOT_W     = 2;
    localparam int FILL_W     = 2;
    localparam int TEMP_W     = 12;
    localparam int HYST_W     = 9;
    localparam int SUM_W      = 14;
    localparam int NUM_W      = 14;
    localparam int DIV_W      = 3;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(NUM_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 1'b1;

    localparam logic signed [TEMP_W-1:0] SETPOINT_RST   = 12'sd350;
    localparam logic [HYST_W-1:0]        HYSTERESIS_RST = 9'd20;

    typedef enum logic [1:0] {
        FAN_NO_CHANGE    = 2'd0,
        FAN_SWITCHED_ON  = 2'd1,
        FAN_SWITCHED_OFF = 2'd2
    } fan_event_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] sample_tenths;
        logic                     sample_valid;
    } in_item_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] average_tenths;
        logic                     average_valid;
        logic                     fan_on;
        fan_event_t               fan_event;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic sum;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_valid;
        logic div_last;
    } dp_status_t;

endpackage

>>> design/aht_ctrl.sv
module aht_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output aht_pkg::ctrl_cmd_t  cmd,
    input  aht_pkg::dp_status_t status
);
    import aht_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SUM    = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = status.item_valid ? ST_DIV : ST_DECIDE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_finish_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("result written over an untaken result");

    a_accept_to_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SUM))
        else $error("accepted item did not start summing");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && status.div_last) |=> (state_reg == ST_DECIDE))
        else $error("divider did not hand over to decision");

    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("finished item not presented");

endmodule

>>> design/aht_datapath.sv
module aht_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  aht_pkg::in_item_t                 s_item,
    input  logic                              cfg_we,
    input  logic [aht_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aht_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  aht_pkg::ctrl_cmd_t                cmd,
    output aht_pkg::dp_status_t               status,
    output aht_pkg::out_item_t                m_item
);
    import aht_pkg::*;

    logic signed [TEMP_W-1:0] ring_reg [RING_DEPTH];
    logic [SLOT_W-1:0]        slot_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic                     item_valid_reg;
    logic signed [TEMP_W-1:0] setpoint_reg;
    logic [HYST_W-1:0]        hyst_reg;

    logic                     sum_neg_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DIV_W-1:0]         div_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic signed [TEMP_W-1:0] held_reg;
    logic                     held_valid_reg;
    logic                     fan_reg;
    out_item_t                out_reg;

    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         mag;
    logic [NUM_W-1:0]         numer;
    logic [DIV_W:0]           rem_sh;
    logic                     q_bit;
    logic [TEMP_W-1:0]        q_low;
    logic signed [TEMP_W-1:0] avg_new;
    logic signed [TEMP_W-1:0] avg_eff;
    logic                     have_avg;
    logic signed [TEMP_W:0]   avg_ext;
    logic signed [TEMP_W:0]   sp_ext;
    logic signed [TEMP_W:0]   off_level;
    logic                     fan_next;
    fan_event_t               event_next;

    assign status.item_valid = item_valid_reg;
    assign status.div_last   = (cnt_reg == DIV_LAST_STEP);
    assign m_item            = out_reg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            if (FILL_W'(i) < fill_reg) begin
                sum = sum + SUM_W'(ring_reg[i]);
            end
        end
        mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        numer = NUM_W'({mag[SUM_W-2:0], 1'b0}) + NUM_W'(fill_reg);
    end

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, div_reg});

    always_comb begin
        q_low      = num_reg[TEMP_W-1:0];
        avg_new    = sum_neg_reg ? $signed(-q_low) : $signed(q_low);
        avg_eff    = item_valid_reg ? avg_new : held_reg;
        have_avg   = item_valid_reg || held_valid_reg;
        avg_ext    = {avg_eff[TEMP_W-1], avg_eff};
        sp_ext     = {setpoint_reg[TEMP_W-1], setpoint_reg};
        off_level  = sp_ext - $signed({{(TEMP_W + 1 - HYST_W){1'b0}}, hyst_reg});
        fan_next   = fan_reg;
        event_next = FAN_NO_CHANGE;
        if (have_avg) begin
            if (!fan_reg) begin
                if (avg_ext >= sp_ext) begin
                    fan_next   = 1'b1;
                    event_next = FAN_SWITCHED_ON;
                end
            end else if (avg_ext <= off_level) begin
                fan_next   = 1'b0;
                event_next = FAN_SWITCHED_OFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= SETPOINT_RST;
            hyst_reg     <= HYSTERESIS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SETPOINT:   setpoint_reg <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_HYSTERESIS: hyst_reg     <= cfg_wdata[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && s_item.sample_valid) begin
            ring_reg[slot_reg] <= s_item.sample_tenths;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg       <= '0;
            fill_reg       <= '0;
            item_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            fan_reg        <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            if (cmd.load) begin
                item_valid_reg <= s_item.sample_valid;
                if (s_item.sample_valid) begin
                    slot_reg <= (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                    if (fill_reg != FILL_W'(RING_DEPTH)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
            end
            if (cmd.sum) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.finish) begin
                held_valid_reg <= have_avg;
                fan_reg        <= fan_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            sum_neg_reg <= sum[SUM_W-1];
            num_reg     <= numer;
            div_reg     <= {fill_reg, 1'b0};
            rem_reg     <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? DIV_W'(rem_sh - {1'b0, div_reg}) : rem_sh[DIV_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
        end
        if (cmd.finish) begin
            held_reg               <= avg_eff;
            out_reg.average_tenths <= have_avg ? avg_eff : '0;
            out_reg.average_valid  <= have_avg;
            out_reg.fan_on         <= fan_next;
            out_reg.fan_event      <= event_next;
        end
    end

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_slot_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg < SLOT_W'(RING_DEPTH))
        else $error("write slot beyond ring depth");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    a_event_matches_fan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> ((out_reg.fan_event == FAN_NO_CHANGE)
                        || (out_reg.fan_on == (out_reg.fan_event == FAN_SWITCHED_ON))))
        else $error("fan event disagrees with fan level");

endmodule

>>> design/averaged_hysteresis_thermostat_core.sv
// Thermostat core: each input item carries a temperature in tenths of a degree and a
// sensor-good flag. A good reading enters a three-deep window; the rounded mean of the
// filled entries (half away from zero) drives a fan comparator that switches on at or
// above the setpoint and off at or below setpoint minus hysteresis. A bad reading
// re-uses the last mean; before any good reading the result reports no average and
// leaves the fan alone. A good reading passes from the accepting edge through the summing
// state, 14 steps of the bit-serial divider that scales by the fill count, and the
// decision state to the result; a bad reading goes from the summing state straight to
// the decision state. The next item can be taken once the previous result is in the
// output register, so the core works on one item at a time; a result left waiting
// holds the core in its decision cycle. Configuration writes are taken at any edge with
// cfg_we high and must only be issued while the core is idle.
module averaged_hysteresis_thermostat_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  aht_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output aht_pkg::out_item_t             m_item,
    input  logic                           cfg_we,
    input  logic [aht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aht_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import aht_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    aht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    aht_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_item    (m_item)
    );

endmodule
